>>> hw/rtl/packbits_run_length_encoder_top_assert.svh
`ifndef PACKBITS_RUN_LENGTH_ENCODER_TOP_ASSERT_SVH
`define PACKBITS_RUN_LENGTH_ENCODER_TOP_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define PBRLE_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define PBRLE_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> hw/rtl/pbrle_pkg.sv
`default_nettype none

package pbrle_pkg;

	localparam int MAX_SEGMENT_DEF = 128;
	localparam int OUT_LANES_DEF   = 4;

	localparam logic [7:0] END_MARK = 8'd128;
	// 257 folded into eight bits
	localparam logic [7:0] RUN_BIAS = 8'd1;

	localparam logic ACT_DATA = 1'b0;
	localparam logic ACT_END  = 1'b1;

	localparam logic [1:0] SEG_NONE = 2'd0;
	localparam logic [1:0] SEG_RUN  = 2'd1;
	localparam logic [1:0] SEG_LIT  = 2'd2;

	typedef struct packed {
		logic       action;
		logic [7:0] in_byte;
	} item_t;

	typedef struct packed {
		logic [31:0] out_word;
		logic [2:0]  out_count;
		logic        out_last;
	} res_t;

	typedef struct packed {
		logic       go;
		logic [1:0] kind;
		logic [7:0] hdr;
		logic [7:0] run_byte;
		logic [7:0] lit_n;
		logic       add_end;
		logic       defer;
		logic [7:0] defer_byte;
	} job_t;

	typedef struct packed {
		logic       valid;
		logic [7:0] data;
		logic       last;
	} beat_t;

endpackage

`default_nettype wire

>>> hw/rtl/packbits_run_length_encoder_top.sv
// channel | beat type          | handshake
// item    | pbrle_pkg::item_t  | item_valid / item_ready
// res     | pbrle_pkg::res_t   | res_valid / res_ready
//
// A byte that only extends the open segment starts no drain.
// A byte or end item that writes a segment drains its bytes (header, body,
// end mark), one a cycle unless res stalls, literal bytes out of the store.
// The literal store is a single-port-write, registered-read memory.
// item_ready drops while a segment drains; res stalls stop the drain.
// Reset clears the state registers, but not the job fields or literal store.
`default_nettype none

`include "packbits_run_length_encoder_top_assert.svh"

module packbits_run_length_encoder_top #(
	parameter int MAX_SEGMENT = pbrle_pkg::MAX_SEGMENT_DEF,
	parameter int OUT_LANES   = pbrle_pkg::OUT_LANES_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             item_valid,
	output logic                  item_ready,
	input  wire pbrle_pkg::item_t item,
	output logic                  res_valid,
	input  wire logic             res_ready,
	output pbrle_pkg::res_t       res
);

	localparam int AW    = $clog2(MAX_SEGMENT);
	localparam int LANES = (OUT_LANES > 4) ? 4 : OUT_LANES;

	logic             accept;
	logic             busy;
	logic             take;
	logic             wr_en;
	logic [AW-1:0]    wr_addr;
	logic [7:0]       wr_data;
	pbrle_pkg::job_t  job;
	pbrle_pkg::beat_t beat;

	assign item_ready = !busy;
	assign accept     = item_valid && item_ready;

	pbrle_plan #(
		.MAX_SEGMENT(MAX_SEGMENT)
	) u_plan (
		.clk     (clk),
		.arst_n  (arst_n),
		.accept  (accept),
		.item    (item),
		.job     (job),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data)
	);

	pbrle_emit #(
		.MAX_SEGMENT(MAX_SEGMENT)
	) u_emit (
		.clk     (clk),
		.arst_n  (arst_n),
		.job     (job),
		.wr_en   (wr_en),
		.wr_addr (wr_addr),
		.wr_data (wr_data),
		.take    (take),
		.beat    (beat),
		.busy    (busy)
	);

	pbrle_pack #(
		.OUT_LANES(OUT_LANES)
	) u_pack (
		.clk       (clk),
		.arst_n    (arst_n),
		.beat      (beat),
		.take      (take),
		.res       (res),
		.res_valid (res_valid),
		.res_ready (res_ready)
	);

	`PBRLE_ASSERT_NEXT(a_end_drains, accept && item.action, busy, "end item did not start a drain")
	`PBRLE_ASSERT_NOW(a_count_range, res_valid, (res.out_count != 3'd0) && (res.out_count <= 3'(LANES)), "word count out of range")
	`PBRLE_ASSERT_NOW(a_more_pending, res_valid && !res.out_last, busy, "non-final word with emitter idle")
	`PBRLE_ASSERT_NOW(a_lanes_clean, res_valid && (res.out_count < 3'd4), (res.out_word >> {res.out_count, 3'b000}) == 32'd0, "unused lanes not zero")

endmodule

`default_nettype wire

>>> hw/rtl/pbrle_plan.sv
`default_nettype none

module pbrle_plan #(
	parameter int MAX_SEGMENT = pbrle_pkg::MAX_SEGMENT_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                accept,
	input  wire pbrle_pkg::item_t                    item,
	output pbrle_pkg::job_t                          job,
	output logic                                     wr_en,
	output logic [$clog2(MAX_SEGMENT)-1:0]           wr_addr,
	output logic [7:0]                               wr_data
);

	localparam int AW = $clog2(MAX_SEGMENT);
	localparam int CW = $clog2(MAX_SEGMENT + 1);

	logic [CW-1:0] p_q, p_d;
	logic          rm_q, rm_d;
	logic [7:0]    lb_q, lb_d;
	logic [7:0]    slb_q, slb_d;
	logic          slv_q, slv_d;

	logic [7:0] p8;
	logic [7:0] b;
	logic       full;
	logic       open_lit;
	logic       put_run;
	logic       put_lit;

	assign p8      = 8'(p_q);
	assign b       = item.in_byte;
	assign full    = (p_q >= CW'(MAX_SEGMENT));
	assign wr_addr = p_q[AW-1:0];
	assign wr_data = b;

	always_comb begin
		job            = '0;
		job.kind       = pbrle_pkg::SEG_NONE;
		job.run_byte   = lb_q;
		job.defer_byte = b;
		job.lit_n      = p8;
		job.hdr        = p8 - 8'd1;
		p_d      = p_q;
		rm_d     = rm_q;
		lb_d     = lb_q;
		slb_d    = slb_q;
		slv_d    = slv_q;
		wr_en    = 1'b0;
		open_lit = 1'b0;
		put_run  = 1'b0;
		put_lit  = 1'b0;
		if (accept) begin
			if (item.action) begin
				job.go      = 1'b1;
				job.add_end = 1'b1;
				if (p_q != '0) begin
					put_run = rm_q;
					put_lit = !rm_q;
				end
				p_d   = '0;
				rm_d  = 1'b0;
				lb_d  = '0;
				slb_d = '0;
				slv_d = 1'b0;
			end else if (p_q == '0) begin
				open_lit = 1'b1;
				wr_en    = 1'b1;
			end else if (b == lb_q) begin
				if (rm_q) begin
					if (full) begin
						put_run   = 1'b1;
						open_lit  = 1'b1;
						job.defer = 1'b1;
					end else begin
						p_d = p_q + 1'b1;
					end
				end else if (slv_q && (slb_q == lb_q)) begin
					put_lit   = 1'b1;
					job.lit_n = p8 - 8'd2;
					job.hdr   = p8 - 8'd3;
					p_d       = CW'(3);
					rm_d      = 1'b1;
					slv_d     = 1'b0;
				end else if (full) begin
					put_lit   = 1'b1;
					open_lit  = 1'b1;
					job.defer = 1'b1;
				end else begin
					wr_en = 1'b1;
					slb_d = lb_q;
					slv_d = 1'b1;
					p_d   = p_q + 1'b1;
					if (p_q == CW'(1)) begin
						rm_d  = 1'b1;
						slv_d = 1'b0;
					end
				end
			end else begin
				if (rm_q) begin
					put_run   = 1'b1;
					open_lit  = 1'b1;
					job.defer = 1'b1;
				end else if (full) begin
					put_lit   = 1'b1;
					open_lit  = 1'b1;
					job.defer = 1'b1;
				end else begin
					wr_en = 1'b1;
					slb_d = lb_q;
					slv_d = 1'b1;
					lb_d  = b;
					p_d   = p_q + 1'b1;
				end
			end
			if (open_lit) begin
				lb_d  = b;
				p_d   = CW'(1);
				rm_d  = 1'b0;
				slv_d = 1'b0;
			end
			if (put_run) begin
				job.go   = 1'b1;
				job.kind = pbrle_pkg::SEG_RUN;
				job.hdr  = pbrle_pkg::RUN_BIAS - p8;
			end
			if (put_lit) begin
				job.go   = 1'b1;
				job.kind = pbrle_pkg::SEG_LIT;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			p_q   <= '0;
			rm_q  <= 1'b0;
			lb_q  <= '0;
			slb_q <= '0;
			slv_q <= 1'b0;
		end else begin
			p_q   <= p_d;
			rm_q  <= rm_d;
			lb_q  <= lb_d;
			slb_q <= slb_d;
			slv_q <= slv_d;
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/pbrle_emit.sv
`default_nettype none

module pbrle_emit #(
	parameter int MAX_SEGMENT = pbrle_pkg::MAX_SEGMENT_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire pbrle_pkg::job_t                     job,
	input  wire logic                                wr_en,
	input  wire logic [$clog2(MAX_SEGMENT)-1:0]      wr_addr,
	input  wire logic [7:0]                          wr_data,
	input  wire logic                                take,
	output pbrle_pkg::beat_t                         beat,
	output logic                                     busy
);

	localparam int AW = $clog2(MAX_SEGMENT);

	localparam logic [1:0] PH_HDR  = 2'd0;
	localparam logic [1:0] PH_BODY = 2'd1;
	localparam logic [1:0] PH_END  = 2'd2;

	logic [7:0]    store_q [MAX_SEGMENT];
	logic [7:0]    rd_data_q;

	logic          busy_q;
	logic [1:0]    phase_q;
	logic [AW-1:0] idx_q, idx_d;
	logic [1:0]    kind_q;
	logic [7:0]    hdr_q;
	logic [7:0]    runb_q;
	logic [7:0]    litn_q;
	logic          end_q;
	logic          defer_q;
	logic [7:0]    defb_q;

	logic          body_done;
	logic          finish;
	logic          we;
	logic [AW-1:0] wa;
	logic [7:0]    wd;

	assign busy = busy_q;

	always_comb begin
		beat.valid = busy_q;
		beat.data  = '0;
		beat.last  = 1'b0;
		body_done  = 1'b0;
		unique case (phase_q)
			PH_HDR: begin
				beat.data = hdr_q;
			end
			PH_BODY: begin
				if (kind_q == pbrle_pkg::SEG_RUN) begin
					beat.data = runb_q;
					body_done = 1'b1;
				end else begin
					beat.data = rd_data_q;
					body_done = (8'(idx_q) == (litn_q - 8'd1));
				end
				beat.last = body_done && !end_q;
			end
			PH_END: begin
				beat.data = pbrle_pkg::END_MARK;
				beat.last = 1'b1;
			end
			default: begin
				beat.valid = 1'b0;
			end
		endcase
	end

	assign finish = take && beat.last;

	always_comb begin
		idx_d = idx_q;
		if (job.go) begin
			idx_d = '0;
		end else if (take && (phase_q == PH_BODY) && !body_done) begin
			idx_d = idx_q + 1'b1;
		end
	end

	// hold the restart byte until the old segment is sent out
	assign we = wr_en || (finish && defer_q);
	assign wa = wr_en ? wr_addr : '0;
	assign wd = wr_en ? wr_data : defb_q;

	always_ff @(posedge clk) begin
		if (we) begin
			store_q[wa] <= wd;
		end
		rd_data_q <= store_q[idx_d];
	end

	always_ff @(posedge clk) begin
		if (job.go) begin
			kind_q  <= job.kind;
			hdr_q   <= job.hdr;
			runb_q  <= job.run_byte;
			litn_q  <= job.lit_n;
			end_q   <= job.add_end;
			defer_q <= job.defer;
			defb_q  <= job.defer_byte;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q  <= 1'b0;
			phase_q <= PH_HDR;
			idx_q   <= '0;
		end else begin
			idx_q <= idx_d;
			if (job.go) begin
				busy_q  <= 1'b1;
				phase_q <= (job.kind == pbrle_pkg::SEG_NONE) ? PH_END : PH_HDR;
			end else if (take) begin
				if (beat.last) begin
					busy_q <= 1'b0;
				end
				unique case (phase_q)
					PH_HDR: begin
						phase_q <= PH_BODY;
					end
					PH_BODY: begin
						if (body_done) begin
							phase_q <= PH_END;
						end
					end
					default: begin
						phase_q <= phase_q;
					end
				endcase
			end
		end
	end

endmodule

`default_nettype wire

>>> hw/rtl/pbrle_pack.sv
`default_nettype none

module pbrle_pack #(
	parameter int OUT_LANES = pbrle_pkg::OUT_LANES_DEF
) (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire pbrle_pkg::beat_t beat,
	output logic                  take,
	output pbrle_pkg::res_t       res,
	output logic                  res_valid,
	input  wire logic             res_ready
);

	localparam int LANES = (OUT_LANES > 4) ? 4 : OUT_LANES;

	logic [31:0] acc_q;
	logic [1:0]  cnt_q;
	logic        res_valid_q;
	pbrle_pkg::res_t res_q;

	logic [31:0] word_d;
	logic [2:0]  cnt_d;
	logic        complete;
	logic        out_free;

	assign word_d   = acc_q | (32'(beat.data) << {cnt_q, 3'b000});
	assign cnt_d    = {1'b0, cnt_q} + 3'd1;
	assign complete = (cnt_d == 3'(LANES)) || beat.last;
	assign out_free = !res_valid_q || res_ready;
	assign take     = beat.valid && (!complete || out_free);

	assign res       = res_q;
	assign res_valid = res_valid_q;

	always_ff @(posedge clk) begin
		if (take && complete) begin
			res_q.out_word  <= word_d;
			res_q.out_count <= cnt_d;
			res_q.out_last  <= beat.last;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q       <= '0;
			cnt_q       <= '0;
			res_valid_q <= 1'b0;
		end else if (take && complete) begin
			acc_q       <= '0;
			cnt_q       <= '0;
			res_valid_q <= 1'b1;
		end else begin
			if (res_ready) begin
				res_valid_q <= 1'b0;
			end
			if (take) begin
				acc_q <= word_d;
				cnt_q <= cnt_d[1:0];
			end
		end
	end

endmodule

`default_nettype wire
